>>> rtl/core/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types, register map and defaults for the threshold peak tagger.
// ----------------------------------------------------------------------------
package tpt_pkg;

  // Default build parameters
  localparam int DEFAULT_MAX_WINDOW    = 256;
  localparam int DEFAULT_POSITION_BITS = 48;

  // Fixed field widths
  localparam int SAMPLE_BITS  = 16;
  localparam int WINLEN_BITS  = 9;
  localparam int OFFSET_BITS  = 10;
  localparam int HOLDOFF_BITS = 16;
  localparam int TAGPOS_BITS  = 48;

  // Configuration port
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  // Register indexes (byte address is 4 * index)
  typedef enum logic [1:0] {
    REG_THRESHOLD       = 2'd0,
    REG_WINDOW_LENGTH   = 2'd1,
    REG_POSITION_OFFSET = 2'd2,
    REG_HOLDOFF_LENGTH  = 2'd3
  } reg_idx_t;

  // Reset values
  localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_RST = 16'sd8192;
  localparam logic [WINLEN_BITS-1:0]        WINLEN_RST    = 9'd16;
  localparam logic signed [OFFSET_BITS-1:0] OFFSET_RST    = 10'sd0;
  localparam logic [HOLDOFF_BITS-1:0]       HOLDOFF_RST   = 16'd0;

  // Configuration as seen by the search logic
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] threshold;
    logic [WINLEN_BITS-1:0]        window_length;
    logic signed [OFFSET_BITS-1:0] position_offset;
    logic [HOLDOFF_BITS-1:0]       holdoff_length;
  } cfg_t;

endpackage

>>> rtl/core/threshold_peak_tagger.sv
// ----------------------------------------------------------------------------
// threshold_peak_tagger
// Passes samples through and tags the window maximum after each crossing.
// ----------------------------------------------------------------------------
//  Channel   Handshake                          Payload
//  sample    sample_valid / sample_ready        sample_in
//  result    result_valid / result_ready        sample_out, tag_valid,
//                                               tag_position, tag_value
//  config    APB psel/penable/pwrite/pready     paddr, pwdata, prdata
//
//  One sample per clock sustained while result_ready is high; input register,
//  then one pass of compare/add logic into the result register.
//  The longest path runs from the blanking end add through the crossing
//  compare and peak select into the tag position add.
//  The input register holds one more sample while a result is stalled.
//  Synchronous reset clears position count, search and blanking state.
// ----------------------------------------------------------------------------
module threshold_peak_tagger #(
  parameter int MAX_WINDOW    = tpt_pkg::DEFAULT_MAX_WINDOW,
  parameter int POSITION_BITS = tpt_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // sample channel
  input  logic                                   sample_valid,
  output logic                                   sample_ready,
  input  logic signed [tpt_pkg::SAMPLE_BITS-1:0] sample_in,
  // result channel
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic signed [tpt_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                                   tag_valid,
  output logic [tpt_pkg::TAGPOS_BITS-1:0]        tag_position,
  output logic signed [tpt_pkg::SAMPLE_BITS-1:0] tag_value,
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tpt_pkg::CFG_ADDR_BITS-1:0]      paddr,
  input  logic [tpt_pkg::CFG_DATA_BITS-1:0]      pwdata,
  output logic [tpt_pkg::CFG_DATA_BITS-1:0]      prdata,
  output logic                                   pready
);

  tpt_pkg::cfg_t                          cfg;
  logic                                   in_full;
  logic signed [tpt_pkg::SAMPLE_BITS-1:0] in_sample;
  logic                                   advance;
  logic                                   tag_hit;
  logic signed [tpt_pkg::SAMPLE_BITS-1:0] tag_val_w;
  logic [POSITION_BITS-1:0]               tag_pos_w;

  tpt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register moves on whenever the result register is free
  assign advance      = in_full && (!result_valid || result_ready);
  assign sample_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      in_sample <= sample_in;
    end
  end

  tpt_search #(
    .MAX_WINDOW    (MAX_WINDOW),
    .POSITION_BITS (POSITION_BITS)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .sample       (in_sample),
    .cfg          (cfg),
    .tag_valid    (tag_hit),
    .tag_value    (tag_val_w),
    .tag_position (tag_pos_w)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out   <= in_sample;
      tag_valid    <= tag_hit;
      tag_value    <= tag_val_w;
      tag_position <= tpt_pkg::TAGPOS_BITS'(64'(tag_pos_w));
    end
  end

endmodule

>>> rtl/core/tpt_cfg.sv
// ----------------------------------------------------------------------------
// tpt_cfg
// APB register file holding threshold, window, offset and hold-off settings.
// ----------------------------------------------------------------------------
module tpt_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tpt_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [tpt_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [tpt_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output tpt_pkg::cfg_t                      cfg
);

  tpt_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = tpt_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold       <= tpt_pkg::THRESHOLD_RST;
      cfg.window_length   <= tpt_pkg::WINLEN_RST;
      cfg.position_offset <= tpt_pkg::OFFSET_RST;
      cfg.holdoff_length  <= tpt_pkg::HOLDOFF_RST;
    end else if (wr_en) begin
      case (idx)
        tpt_pkg::REG_THRESHOLD: begin
          cfg.threshold <= pwdata[tpt_pkg::SAMPLE_BITS-1:0];
        end
        tpt_pkg::REG_WINDOW_LENGTH: begin
          cfg.window_length <= pwdata[tpt_pkg::WINLEN_BITS-1:0];
        end
        tpt_pkg::REG_POSITION_OFFSET: begin
          cfg.position_offset <= pwdata[tpt_pkg::OFFSET_BITS-1:0];
        end
        tpt_pkg::REG_HOLDOFF_LENGTH: begin
          cfg.holdoff_length <= pwdata[tpt_pkg::HOLDOFF_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read mux, signed fields sign-extended
  always_comb begin
    case (idx)
      tpt_pkg::REG_THRESHOLD:       prdata = 32'(cfg.threshold);
      tpt_pkg::REG_WINDOW_LENGTH:   prdata = 32'(cfg.window_length);
      tpt_pkg::REG_POSITION_OFFSET: prdata = 32'(cfg.position_offset);
      tpt_pkg::REG_HOLDOFF_LENGTH:  prdata = 32'(cfg.holdoff_length);
      default:                      prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/tpt_search.sv
// ----------------------------------------------------------------------------
// tpt_search
// Crossing detection, window maximum tracking, tag position and blanking.
// ----------------------------------------------------------------------------
module tpt_search #(
  parameter int MAX_WINDOW    = tpt_pkg::DEFAULT_MAX_WINDOW,
  parameter int POSITION_BITS = tpt_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   step,
  input  logic signed [tpt_pkg::SAMPLE_BITS-1:0] sample,
  input  tpt_pkg::cfg_t                          cfg,
  output logic                                   tag_valid,
  output logic signed [tpt_pkg::SAMPLE_BITS-1:0] tag_value,
  output logic [POSITION_BITS-1:0]               tag_position
);

  localparam int PB  = POSITION_BITS;
  localparam int WCW = $clog2(MAX_WINDOW + 1);
  localparam int CW  = (WCW > tpt_pkg::WINLEN_BITS) ? WCW : tpt_pkg::WINLEN_BITS;

  // Saturating add at the all-ones position
  function automatic logic [PB-1:0] sat_add(input logic [PB-1:0] a,
                                            input logic [PB-1:0] b);
    logic [PB:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[PB] ? {PB{1'b1}} : s[PB-1:0];
  endfunction

  // State
  logic [PB-1:0]                        sample_count;
  logic [PB-1:0]                        blank_until;
  logic                                 blank_pending;
  logic [PB-1:0]                        last_tag_pos;
  logic [tpt_pkg::HOLDOFF_BITS-1:0]     last_holdoff;
  logic                                 searching;
  logic [WCW-1:0]                       window_count;
  logic signed [tpt_pkg::SAMPLE_BITS-1:0] peak_value;
  logic [PB-1:0]                        peak_position;

  // Per-sample logic
  logic [PB-1:0]                        blank_eff;
  logic                                 crossing;
  logic                                 take_sample;
  logic                                 searching_mid;
  logic [WCW-1:0]                       count_mid;
  logic signed [tpt_pkg::SAMPLE_BITS-1:0] peak_value_mid;
  logic [PB-1:0]                        peak_pos_mid;
  logic [CW-1:0]                        win_eff;
  logic                                 emit;
  logic [PB:0]                          pos_sum;
  logic [PB:0]                          pos_diff;
  logic [tpt_pkg::OFFSET_BITS-1:0]      off_mag;
  logic [PB-1:0]                        tpos;

  // Blanking end: the last tag's sum is resolved in the cycle after the tag
  assign blank_eff = blank_pending ? sat_add(last_tag_pos, PB'(last_holdoff)) : blank_until;

  assign crossing    = !searching && (sample_count >= blank_eff) && (sample > cfg.threshold);
  assign take_sample = crossing || (searching && (sample > peak_value));
  assign searching_mid  = searching || crossing;
  assign count_mid      = searching ? (window_count + WCW'(1)) : WCW'(1);
  assign peak_value_mid = take_sample ? sample : peak_value;
  assign peak_pos_mid   = take_sample ? sample_count : peak_position;

  // Effective window: zero acts as one, clamp at the maximum
  always_comb begin
    win_eff = CW'(cfg.window_length);
    if (win_eff == '0) begin
      win_eff = CW'(1);
    end
    if (win_eff > CW'(MAX_WINDOW)) begin
      win_eff = CW'(MAX_WINDOW);
    end
  end

  assign emit = searching_mid && (CW'(count_mid) >= win_eff);

  // Tag position: peak plus offset, saturated at both ends
  assign off_mag  = tpt_pkg::OFFSET_BITS'(-cfg.position_offset);
  assign pos_sum  = {1'b0, peak_pos_mid} + (PB + 1)'(cfg.position_offset[8:0]);
  assign pos_diff = {1'b0, peak_pos_mid} - (PB + 1)'(off_mag);

  always_comb begin
    if (!cfg.position_offset[tpt_pkg::OFFSET_BITS-1]) begin
      tpos = pos_sum[PB] ? {PB{1'b1}} : pos_sum[PB-1:0];
    end else begin
      tpos = pos_diff[PB] ? '0 : pos_diff[PB-1:0];
    end
  end

  assign tag_valid    = emit;
  assign tag_value    = emit ? peak_value_mid : '0;
  assign tag_position = emit ? tpos : '0;

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      blank_until   <= '0;
      blank_pending <= 1'b0;
      last_tag_pos  <= '0;
      last_holdoff  <= '0;
      searching     <= 1'b0;
      window_count  <= '0;
      peak_value    <= '0;
      peak_position <= '0;
    end else begin
      // fold a pending blanking end into the register
      if (blank_pending) begin
        blank_until <= blank_eff;
      end
      blank_pending <= step && emit;
      if (step) begin
        sample_count  <= sample_count + PB'(1);
        searching     <= searching_mid && !emit;
        window_count  <= (emit || !searching_mid) ? '0 : count_mid;
        peak_value    <= peak_value_mid;
        peak_position <= peak_pos_mid;
        if (emit) begin
          last_tag_pos <= tpos;
          last_holdoff <= cfg.holdoff_length;
        end
      end
    end
  end

endmodule

>>> rtl/core/tpt_checker.sv
// ----------------------------------------------------------------------------
// tpt_checker
// Port-level checks on the threshold peak tagger, bound to the top level.
// ----------------------------------------------------------------------------
module tpt_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   sample_ready,
  input logic                                   result_valid,
  input logic                                   result_ready,
  input logic signed [tpt_pkg::SAMPLE_BITS-1:0] sample_out,
  input logic                                   tag_valid,
  input logic [tpt_pkg::TAGPOS_BITS-1:0]        tag_position,
  input logic signed [tpt_pkg::SAMPLE_BITS-1:0] tag_value
);

  // A stalled result transfer keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(sample_out) &&
      $stable(tag_valid) && $stable(tag_position) && $stable(tag_value))
    else $error("result payload changed while stalled");

  // Untagged results carry zero tag fields
  a_untagged_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !tag_valid |-> tag_position == '0 && tag_value == '0)
    else $error("tag fields non-zero without a tag");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

  // With no result waiting, a new sample is always taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> sample_ready)
    else $error("sample stalled with an empty result register");

endmodule

bind threshold_peak_tagger tpt_checker u_tpt_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .sample_out   (sample_out),
  .tag_valid    (tag_valid),
  .tag_position (tag_position),
  .tag_value    (tag_value)
);

>>> tb/tb_threshold_peak_tagger.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_threshold_peak_tagger
// Self-checking bench for the threshold peak tagger. A scoreboard keeps its
// own copy of the search state and register settings, predicts the result of
// every sample transfer, and checks each result transfer field by field.
// Stimulus is a short directed run, then phases of random samples shaped
// around the threshold, with register rewrites between phases and random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------

localparam logic [47:0] TAG_POS_MAX = '1;

// One result transfer: the sample passed through and an optional tag
typedef struct packed {
  logic signed [15:0] smp;
  logic               tag;
  logic [47:0]        pos;
  logic signed [15:0] val;
} sample_tag_t;

// Predicts the tags and checks the results against them
class peak_tag_scoreboard;
  logic signed [15:0] threshold;
  logic [8:0]         window_length;
  logic signed [9:0]  position_offset;
  logic [15:0]        holdoff_length;

  logic [47:0]        sample_pos;
  logic [47:0]        blank_end;
  logic [47:0]        peak_pos;
  logic signed [15:0] peak_val;
  bit                 searching;
  int unsigned        window_fill;

  sample_tag_t        expected_tags[$];
  int                 mismatches;
  int                 results_seen;

  function new();
    threshold       = tpt_pkg::THRESHOLD_RST;
    window_length   = tpt_pkg::WINLEN_RST;
    position_offset = tpt_pkg::OFFSET_RST;
    holdoff_length  = tpt_pkg::HOLDOFF_RST;
    sample_pos      = '0;
    blank_end       = '0;
    peak_pos        = '0;
    peak_val        = '0;
    searching       = 1'b0;
    window_fill     = 0;
    mismatches      = 0;
    results_seen    = 0;
  endfunction

  function void write_reg(tpt_pkg::reg_idx_t idx, logic [31:0] value);
    case (idx)
      tpt_pkg::REG_THRESHOLD:       threshold       = value[15:0];
      tpt_pkg::REG_WINDOW_LENGTH:   window_length   = value[8:0];
      tpt_pkg::REG_POSITION_OFFSET: position_offset = value[9:0];
      tpt_pkg::REG_HOLDOFF_LENGTH:  holdoff_length  = value[15:0];
      default: ;
    endcase
  endfunction

  // Unsigned add clamped to the largest position
  function logic [47:0] sat_add(logic [47:0] a, logic [63:0] b);
    logic [63:0] room;
    room = {16'd0, TAG_POS_MAX} - {16'd0, a};
    if (b >= room) return TAG_POS_MAX;
    return a + b[47:0];
  endfunction

  // Advance the search by one accepted sample and queue the expected result
  function void note_sample(logic signed [15:0] s);
    sample_tag_t res;
    int unsigned win_eff;
    int          off_i;
    logic [47:0] tpos;
    res = '0;
    res.smp = s;
    if (searching) begin
      window_fill++;
      if (s > peak_val) begin
        peak_val = s;
        peak_pos = sample_pos;
      end
    end else if (sample_pos >= blank_end && s > threshold) begin
      searching   = 1'b1;
      window_fill = 1;
      peak_val    = s;
      peak_pos    = sample_pos;
    end
    // zero acts as one, above the maximum clamps
    win_eff = (window_length == 0) ? 1 : window_length;
    if (win_eff > tpt_pkg::DEFAULT_MAX_WINDOW) win_eff = tpt_pkg::DEFAULT_MAX_WINDOW;
    if (searching && window_fill >= win_eff) begin
      off_i = position_offset;
      if (off_i >= 0) begin
        tpos = sat_add(peak_pos, 64'(off_i));
      end else begin
        // negative shift floors at position zero
        tpos = (peak_pos > 48'(-off_i)) ? peak_pos - 48'(-off_i) : '0;
      end
      res.tag     = 1'b1;
      res.pos     = tpos;
      res.val     = peak_val;
      blank_end   = sat_add(tpos, 64'(holdoff_length));
      searching   = 1'b0;
      window_fill = 0;
    end
    sample_pos = sample_pos + 48'd1;
    expected_tags.push_back(res);
  endfunction

  function void report_mismatch(string field, longint got, longint want);
    $display("MISMATCH result %0d %s: got %0d, expected %0d",
             results_seen, field, got, want);
    mismatches++;
  endfunction

  function void check_result(sample_tag_t got);
    sample_tag_t want;
    if (expected_tags.size() == 0) begin
      report_mismatch("unexpected transfer", got.smp, 0);
      return;
    end
    want = expected_tags.pop_front();
    if (got.smp !== want.smp) report_mismatch("sample_out", got.smp, want.smp);
    if (got.tag !== want.tag) report_mismatch("tag_valid", got.tag, want.tag);
    if (got.pos !== want.pos) report_mismatch("tag_position", got.pos, want.pos);
    if (got.val !== want.val) report_mismatch("tag_value", got.val, want.val);
    results_seen++;
  endfunction
endclass

module tb_threshold_peak_tagger;

  localparam int          NUM_PHASES      = 12;
  localparam int          ITEMS_PER_PHASE = 90;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  logic                                   clk = 1'b0;
  logic                                   rst;
  logic                                   sample_valid;
  logic                                   sample_ready;
  logic signed [tpt_pkg::SAMPLE_BITS-1:0] sample_in;
  logic                                   result_valid;
  logic                                   result_ready;
  logic signed [tpt_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                   tag_valid;
  logic [tpt_pkg::TAGPOS_BITS-1:0]        tag_position;
  logic signed [tpt_pkg::SAMPLE_BITS-1:0] tag_value;
  logic                                   psel;
  logic                                   penable;
  logic                                   pwrite;
  logic [tpt_pkg::CFG_ADDR_BITS-1:0]      paddr;
  logic [tpt_pkg::CFG_DATA_BITS-1:0]      pwdata;
  logic [tpt_pkg::CFG_DATA_BITS-1:0]      prdata;
  logic                                   pready;

  peak_tag_scoreboard sb;
  bit                 hold_off_req;
  int unsigned        cycle_count;
  logic signed [15:0] last_sample;

  // Opening run at reset settings: below, at and just over the threshold,
  // a tie on the maximum, then enough samples to close a 16-sample window
  logic signed [15:0] opening_run [0:18] = '{
    16'sd8192, -16'sd32768, 16'sd0, 16'sd8193, 16'sd100, 16'sd32767, 16'sd32767,
    -16'sd1, 16'sd21845, -16'sd21846, 16'sd8193, 16'sd32766, 16'sd0, -16'sd32768,
    16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5
  };

  threshold_peak_tagger uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample_out   (sample_out),
    .tag_valid    (tag_valid),
    .tag_position (tag_position),
    .tag_value    (tag_value),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  // Cycle counter and run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result monitor
  always @(posedge clk) begin : result_mon
    sample_tag_t got;
    if (!rst && result_valid && result_ready) begin
      got.smp = sample_out;
      got.tag = tag_valid;
      got.pos = tag_position;
      got.val = tag_value;
      sb.check_result(got);
    end
  end

  // Receiver: stall patterns in random spans, plus a long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    result_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 80);
      for (int k = 0; k < span; k++) begin
        case (mode)
          0:       result_ready <= 1'b1;
          1:       result_ready <= 1'($urandom_range(0, 1));
          2:       result_ready <= ($urandom_range(0, 3) == 0);
          default: result_ready <= (k % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // One sample transfer; returns at the edge that accepts it
  task automatic send_sample(input logic signed [15:0] value);
    sample_valid <= 1'b1;
    sample_in    <= value;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    sb.note_sample(value);
    last_sample = value;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (sb.expected_tags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input tpt_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic set_config(input int thr, input int win, input int off, input int hold);
    cfg_write(tpt_pkg::REG_THRESHOLD,       {16'd0, 16'(thr)});
    cfg_write(tpt_pkg::REG_WINDOW_LENGTH,   {23'd0, 9'(win)});
    cfg_write(tpt_pkg::REG_POSITION_OFFSET, {22'd0, 10'(off)});
    cfg_write(tpt_pkg::REG_HOLDOFF_LENGTH,  {16'd0, 16'(hold)});
  endtask

  // Random samples in bursts: mostly just below or just above the threshold
  // so that windows open and compete, with some full-range values and ties
  task automatic send_items(input int count, input bit steady);
    int left;
    int burst;
    int gap;
    int pick;
    int thr;
    int v;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      left -= burst;
      repeat (burst) begin
        thr  = sb.threshold;
        pick = $urandom_range(0, 19);
        if (pick <= 8)       v = thr - int'($urandom_range(1, 3000));
        else if (pick <= 14) v = thr + int'($urandom_range(1, 3000));
        else if (pick <= 16) v = int'($urandom_range(0, 65535)) - 32768;
        else if (pick == 17) v = last_sample;
        else if (pick == 18) v = -32768;
        else                 v = 32767;
        if (v < -32768) v = -32768;
        if (v > 32767)  v = 32767;
        send_sample(16'(v));
      end
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Main stimulus
  initial begin : stimulus
    int thr;
    int win;
    int off;
    int hold;
    sb           = new();
    hold_off_req = 1'b0;
    last_sample  = '0;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample_in    <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, one full 16-sample window with a tie on the peak
    foreach (opening_run[i]) send_sample(opening_run[i]);
    wait_idle();

    // lowest threshold, zero window tags on the crossing itself,
    // most negative offset saturates the tag position at zero
    set_config(-32768, 0, -512, 0);
    send_sample(-16'sd32768);
    send_sample(-16'sd32767);
    wait_idle();

    // open a long window, then shorten it below the count mid-search
    set_config(0, 40, 0, 0);
    send_sample(16'sd1);
    send_sample(16'sd32767);
    send_sample(-16'sd5);
    wait_idle();
    cfg_write(tpt_pkg::REG_WINDOW_LENGTH, 32'd2);
    send_sample(16'sd16384);
    wait_idle();

    // random phases, settings rewritten between them
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0:       thr = int'($urandom_range(0, 65535)) - 32768;
        1:       thr = 0;
        default: thr = int'($urandom_range(0, 40000)) - 20000;
      endcase
      case ($urandom_range(0, 5))
        0:       win = 256;
        1:       win = 257;
        2:       win = $urandom_range(0, 511);
        default: win = $urandom_range(1, 20);
      endcase
      off  = int'($urandom_range(0, 575)) - 512;
      hold = $urandom_range(0, 40);
      if (ph == 1) begin
        thr = -32768; win = 0; off = -512; hold = 0;
      end else if (ph == 2) begin
        // never crosses, so the largest offset and window cannot blank later phases
        thr = 32767; win = 511; off = 511; hold = 0;
      end else if (ph == 5) begin
        off = -256;
      end else if (ph == NUM_PHASES - 1) begin
        // last phase: blanking runs past the end of the run
        win = $urandom_range(1, 8); off = 256; hold = 65535;
      end
      set_config(thr, win, off, hold);
      if (ph % 4 == 1) hold_off_req = 1'b1;
      send_items(ITEMS_PER_PHASE, ph % 5 == 3);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tpt_pkg.sv
rtl/core/tpt_cfg.sv
rtl/core/tpt_search.sv
rtl/core/threshold_peak_tagger.sv
rtl/core/tpt_checker.sv
tb/tb_threshold_peak_tagger.sv
